// File: hdl/utf8_validating_decoder_assert.svh
// Assertion macros used by the decoder's back-end module.
`ifndef UTF8_VALIDATING_DECODER_ASSERT_SVH
`define UTF8_VALIDATING_DECODER_ASSERT_SVH

// A condition that holds at every clock edge outside reset.
`define UVD_ASSERT_ALWAYS(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) else $error(msg);

// A consequent that holds in the same cycle as its antecedent.
`define UVD_ASSERT_IMPLY(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// A consequent that holds in the cycle after its antecedent.
`define UVD_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/utf8vd_pkg.sv
package utf8vd_pkg;

    localparam int OFFSET_BITS_DEFAULT = 32;
    localparam int QUEUE_DEPTH = 2;
    localparam int CP_BITS = 21;
    localparam int OUT_OFFSET_BITS = 32;
    localparam int TDATA_BITS = 88;

    localparam logic [CP_BITS-1:0] MARKER_BASE = 21'h110000;
    localparam logic [CP_BITS-1:0] MAX_SCALAR = 21'h10FFFF;
    localparam logic [CP_BITS-1:0] SURR_LOW = 21'h00D800;
    localparam logic [CP_BITS-1:0] SURR_HIGH = 21'h00DFFF;
    localparam logic [CP_BITS-1:0] MIN_TWO = 21'h000080;
    localparam logic [CP_BITS-1:0] MIN_THREE = 21'h000800;
    localparam logic [CP_BITS-1:0] MIN_FOUR = 21'h010000;

    localparam logic [2:0] LEN_BAD = 3'd0;
    localparam logic [2:0] LEN_ONE = 3'd1;
    localparam logic [2:0] LEN_TWO = 3'd2;
    localparam logic [2:0] LEN_THREE = 3'd3;
    localparam logic [2:0] LEN_FOUR = 3'd4;

    typedef struct packed {
        logic [7:0] data;
        logic [2:0] len;
        logic       cont;
    } byte_info_t;

    typedef struct packed {
        byte_info_t info;
        logic       fin;
    } q_item_t;

    typedef struct packed {
        logic [CP_BITS-1:0]         cp;
        logic [OUT_OFFSET_BITS-1:0] start_off;
        logic [OUT_OFFSET_BITS-1:0] end_off;
        logic                       ok;
    } result_t;

    typedef enum logic {
        BK_WAIT,
        BK_EVAL
    } back_state_t;

    function automatic logic [2:0] lead_len(input logic [7:0] b);
        logic [2:0] len;
        len = LEN_BAD;
        if (b[7] == 1'b0) begin
            len = LEN_ONE;
        end else if (b[7:5] == 3'b110) begin
            len = LEN_TWO;
        end else if (b[7:4] == 4'b1110) begin
            len = LEN_THREE;
        end else if (b[7:3] == 5'b11110) begin
            len = LEN_FOUR;
        end
        return len;
    endfunction

endpackage

// File: hdl/utf8vd_front.sv
module utf8vd_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,  // data_byte
    input  logic                s_tlast,  // end_of_text
    output logic                q_valid,
    input  logic                q_ready,
    output utf8vd_pkg::q_item_t q_item
);

    logic                valid_reg;
    logic                valid_next;
    utf8vd_pkg::q_item_t item_reg;
    utf8vd_pkg::q_item_t item_next;
    logic                take;

    assign s_tready = !valid_reg || q_ready;
    assign take = s_tvalid && s_tready;
    assign q_valid = valid_reg;
    assign q_item = item_reg;

    always_comb begin
        valid_next = valid_reg;
        item_next = item_reg;
        if (take) begin
            valid_next = 1'b1;
            item_next.info.data = s_tdata;
            item_next.info.len = utf8vd_pkg::lead_len(s_tdata);
            item_next.info.cont = (s_tdata[7:6] == 2'b10);
            item_next.fin = s_tlast;
        end else if (q_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg <= item_next;
    end

endmodule

// File: hdl/utf8vd_queue.sv
module utf8vd_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                wr_valid,
    output logic                wr_ready,
    input  utf8vd_pkg::q_item_t wr_item,
    output logic                rd_valid,
    input  logic                rd_ready,
    output utf8vd_pkg::q_item_t rd_item
);

    localparam int PTR_BITS = $clog2(utf8vd_pkg::QUEUE_DEPTH);

    utf8vd_pkg::q_item_t       slot_reg [utf8vd_pkg::QUEUE_DEPTH];
    logic [PTR_BITS-1:0]       wr_ptr_reg;
    logic [PTR_BITS-1:0]       wr_ptr_next;
    logic [PTR_BITS-1:0]       rd_ptr_reg;
    logic [PTR_BITS-1:0]       rd_ptr_next;
    logic [PTR_BITS:0]         count_reg;
    logic [PTR_BITS:0]         count_next;
    logic                      push;
    logic                      pop;

    assign wr_ready = (count_reg != (PTR_BITS + 1)'(utf8vd_pkg::QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_item = slot_reg[rd_ptr_reg];
    assign push = wr_valid && wr_ready;
    assign pop = rd_valid && rd_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(utf8vd_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(utf8vd_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

// File: hdl/utf8vd_back.sv
`include "utf8_validating_decoder_assert.svh"

module utf8vd_back #(
    parameter int OFFSET_BITS = utf8vd_pkg::OFFSET_BITS_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                q_valid,
    output logic                                q_ready,
    input  utf8vd_pkg::q_item_t                 q_item,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [utf8vd_pkg::TDATA_BITS-1:0]   m_tdata,
    output logic [1:0]                          m_tuser,
    output logic                                m_tlast
);

    localparam int CPB = utf8vd_pkg::CP_BITS;
    localparam int OOB = utf8vd_pkg::OUT_OFFSET_BITS;

    utf8vd_pkg::back_state_t state_reg;
    utf8vd_pkg::back_state_t state_next;
    utf8vd_pkg::byte_info_t  buf_reg [4];
    utf8vd_pkg::byte_info_t  buf_next [4];
    logic [2:0]              cnt_reg;
    logic [2:0]              cnt_next;
    logic                    fin_reg;
    logic                    fin_next;
    logic [OFFSET_BITS-1:0]  pos_reg;
    logic [OFFSET_BITS-1:0]  pos_next;
    logic                    hold_valid_reg;
    logic                    hold_valid_next;
    utf8vd_pkg::result_t     hold_reg;
    utf8vd_pkg::result_t     hold_next;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    utf8vd_pkg::result_t     out_reg;
    utf8vd_pkg::result_t     out_next;
    logic                    out_last_reg;
    logic                    out_last_next;
    logic                    out_done_reg;
    logic                    out_done_next;

    logic [2:0]              len;
    logic                    cont_ok;
    logic [CPB-1:0]          value;
    logic                    value_ok;
    logic                    emit;
    logic                    emit_ok;
    logic [2:0]              consume;
    logic [CPB-1:0]          emit_cp;
    logic                    slot_free;
    logic                    advance;
    logic [OFFSET_BITS-1:0]  end_pos;
    logic [OFFSET_BITS+OOB-1:0] start_ext;
    logic [OFFSET_BITS+OOB-1:0] end_ext;
    logic [2:0]              src;

    assign len = buf_reg[0].len;
    assign slot_free = !out_valid_reg || m_tready;
    assign advance = !hold_valid_reg || slot_free;

    always_comb begin
        cont_ok = 1'b1;
        for (int i = 1; i < 4; i++) begin
            if ((3'(i) < len) && (3'(i) < cnt_reg) && !buf_reg[i].cont) begin
                cont_ok = 1'b0;
            end
        end
    end

    always_comb begin
        value = '0;
        case (len)
            utf8vd_pkg::LEN_TWO: begin
                value = CPB'({buf_reg[0].data[4:0], buf_reg[1].data[5:0]});
            end
            utf8vd_pkg::LEN_THREE: begin
                value = CPB'({buf_reg[0].data[3:0], buf_reg[1].data[5:0],
                              buf_reg[2].data[5:0]});
            end
            utf8vd_pkg::LEN_FOUR: begin
                value = {buf_reg[0].data[2:0], buf_reg[1].data[5:0],
                         buf_reg[2].data[5:0], buf_reg[3].data[5:0]};
            end
            default: begin
                value = CPB'(buf_reg[0].data);
            end
        endcase
    end

    always_comb begin
        value_ok = 1'b1;
        if ((len == utf8vd_pkg::LEN_TWO) && (value < utf8vd_pkg::MIN_TWO)) begin
            value_ok = 1'b0;
        end
        if ((len == utf8vd_pkg::LEN_THREE) && (value < utf8vd_pkg::MIN_THREE)) begin
            value_ok = 1'b0;
        end
        if ((len == utf8vd_pkg::LEN_FOUR) && (value < utf8vd_pkg::MIN_FOUR)) begin
            value_ok = 1'b0;
        end
        if ((value >= utf8vd_pkg::SURR_LOW) && (value <= utf8vd_pkg::SURR_HIGH)) begin
            value_ok = 1'b0;
        end
        if (value > utf8vd_pkg::MAX_SCALAR) begin
            value_ok = 1'b0;
        end
    end

    // Decision for the sequence that starts at the head of the buffer.
    always_comb begin
        emit = 1'b1;
        emit_ok = 1'b0;
        if (cnt_reg == 3'd0) begin
            emit = 1'b0;
        end else if ((len != utf8vd_pkg::LEN_BAD) && cont_ok) begin
            if (cnt_reg < len) begin
                emit = fin_reg;
            end else begin
                emit_ok = value_ok;
            end
        end
        consume = emit_ok ? len : 3'd1;
        emit_cp = emit_ok ? value : (utf8vd_pkg::MARKER_BASE | CPB'(buf_reg[0].data));
    end

    assign end_pos = pos_reg + OFFSET_BITS'(consume);
    assign start_ext = {{OOB{1'b0}}, pos_reg};
    assign end_ext = {{OOB{1'b0}}, end_pos};

    always_comb begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        fin_next = fin_reg;
        pos_next = pos_reg;
        hold_valid_next = hold_valid_reg;
        hold_next = hold_reg;
        out_next = out_reg;
        out_last_next = out_last_reg;
        out_done_next = out_done_reg;
        out_valid_next = m_tready ? 1'b0 : out_valid_reg;
        q_ready = 1'b0;
        src = '0;
        for (int j = 0; j < 4; j++) begin
            buf_next[j] = buf_reg[j];
        end

        unique case (state_reg)
            utf8vd_pkg::BK_WAIT: begin
                q_ready = 1'b1;
                if (q_valid) begin
                    buf_next[cnt_reg[1:0]] = q_item.info;
                    cnt_next = cnt_reg + 3'd1;
                    fin_next = q_item.fin;
                    state_next = utf8vd_pkg::BK_EVAL;
                end
            end
            utf8vd_pkg::BK_EVAL: begin
                if (advance) begin
                    if (hold_valid_reg) begin
                        out_valid_next = 1'b1;
                        out_next = hold_reg;
                        out_last_next = !emit;
                        out_done_next = !emit && fin_reg;
                    end
                    if (emit) begin
                        hold_valid_next = 1'b1;
                        hold_next.cp = emit_cp;
                        hold_next.start_off = start_ext[OOB-1:0];
                        hold_next.end_off = end_ext[OOB-1:0];
                        hold_next.ok = emit_ok;
                        pos_next = end_pos;
                        cnt_next = cnt_reg - consume;
                        for (int j = 0; j < 4; j++) begin
                            src = 3'(j) + consume;
                            if (src < 3'd4) begin
                                buf_next[j] = buf_reg[src[1:0]];
                            end
                        end
                    end else begin
                        hold_valid_next = 1'b0;
                        if (fin_reg) begin
                            pos_next = '0;
                            fin_next = 1'b0;
                        end
                        q_ready = 1'b1;
                        if (q_valid) begin
                            buf_next[cnt_reg[1:0]] = q_item.info;
                            cnt_next = cnt_reg + 3'd1;
                            fin_next = q_item.fin;
                        end else begin
                            state_next = utf8vd_pkg::BK_WAIT;
                        end
                    end
                end
            end
            default: begin
                state_next = utf8vd_pkg::BK_WAIT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= utf8vd_pkg::BK_WAIT;
            cnt_reg <= '0;
            fin_reg <= 1'b0;
            pos_reg <= '0;
            hold_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            fin_reg <= fin_next;
            pos_reg <= pos_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int j = 0; j < 4; j++) begin
            buf_reg[j] <= buf_next[j];
        end
        hold_reg <= hold_next;
        out_reg <= out_next;
        out_last_reg <= out_last_next;
        out_done_reg <= out_done_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = {3'b000, out_reg.end_off, out_reg.start_off, out_reg.cp};
    assign m_tuser = {out_last_reg, out_reg.ok};
    assign m_tlast = out_done_reg;

    `UVD_ASSERT_IMPLY(a_wait_hold_empty, aclk, aresetn, state_reg == utf8vd_pkg::BK_WAIT, !hold_valid_reg, "A result is held while waiting for a byte.")
    `UVD_ASSERT_IMPLY(a_wait_room, aclk, aresetn, state_reg == utf8vd_pkg::BK_WAIT, cnt_reg <= 3'd3, "The buffer has no room for the next byte.")
    `UVD_ASSERT_NEXT(a_text_end_offset, aclk, aresetn, (state_reg == utf8vd_pkg::BK_EVAL) && !emit && fin_reg && advance, pos_reg == '0, "The offset did not restart after the end of the text.")
    `UVD_ASSERT_ALWAYS(a_cnt_range, aclk, aresetn, cnt_reg <= 3'd4, "The buffer count is out of range.")

endmodule

// File: hdl/utf8_validating_decoder.sv
// UTF-8 validating decoder.
// The input channel (s_) carries one text byte per transfer in s_tdata, with
// s_tlast set on the final byte of a text. The result channel (m_) carries one
// decoded span per transfer: the code point or the malformed-byte marker, its
// start and end byte offsets, a well-formed flag and a last-of-run flag in
// m_tuser, and m_tlast on the final result of the text.
// A byte is registered and classified at the input, then waits in a two-entry
// queue, so input transfers continue while the decoding sequencer is busy.
// While the result path is not stalled, the sequencer takes one byte from the
// queue per cycle while a sequence is still open and produces one result per
// cycle; a result is held back until it is known whether more results follow
// for the same byte. After a malformed byte, the bytes behind it are decoded
// anew. A result passes from the input register through the queue, the
// sequencer buffer and the hold register to the output register.
// Reset empties the queue, the open sequence and the output register and sets
// the byte offset to zero; the offset also restarts after every end of text.
// When the receiver stalls, the output register holds its result, the
// sequencer halts behind it and the queue fills until s_tready falls.
module utf8_validating_decoder #(
    parameter int OFFSET_BITS = utf8vd_pkg::OFFSET_BITS_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,  // data_byte
    input  logic                                s_tlast,  // end_of_text
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // code_point[20:0], start_offset[52:21], end_offset[84:53], zero pad
    output logic [utf8vd_pkg::TDATA_BITS-1:0]   m_tdata,
    output logic [1:0]                          m_tuser,  // well_formed, last_of_run
    output logic                                m_tlast   // text_done
);

    logic                front_valid;
    logic                front_ready;
    utf8vd_pkg::q_item_t front_item;
    logic                back_valid;
    logic                back_ready;
    utf8vd_pkg::q_item_t back_item;

    utf8vd_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_valid  (front_valid),
        .q_ready  (front_ready),
        .q_item   (front_item)
    );

    utf8vd_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (front_valid),
        .wr_ready (front_ready),
        .wr_item  (front_item),
        .rd_valid (back_valid),
        .rd_ready (back_ready),
        .rd_item  (back_item)
    );

    utf8vd_back #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (back_valid),
        .q_ready  (back_ready),
        .q_item   (back_item),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// File: sim/tb_utf8_validating_decoder.sv
`timescale 1ns / 1ps

module tb_utf8_validating_decoder;

    typedef struct packed {
        logic [20:0] code_point;
        logic [31:0] start_off;
        logic [31:0] end_off;
        logic        well_formed;
        logic        last_of_run;
        logic        text_done;
    } span_t;

    typedef struct {
        logic [7:0] data;
        logic       eot;
        bit         drain_first;
    } text_byte_t;

    typedef enum int {
        RDY_ALWAYS,
        RDY_RANDOM,
        RDY_PATTERN,
        RDY_SPARSE
    } ready_mode_t;

    localparam int RANDOM_BYTES = 283;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [utf8vd_pkg::TDATA_BITS-1:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    text_byte_t  text_bytes[$];
    span_t       expected_spans[$];
    logic [7:0]  open_bytes[3] = '{8'h00, 8'h00, 8'h00};
    int          open_count = 0;
    logic [31:0] text_pos = 32'd0;
    int          error_count = 0;
    bit          hold_next = 1'b0;
    logic        byte_taken = 1'b0;
    int          burst_left = 0;
    int          gap_left = 0;
    ready_mode_t ready_mode = RDY_ALWAYS;
    int          phase_left = 0;
    logic [7:0]  stall_pattern = 8'b1011_0110;

    utf8_validating_decoder DUT (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tlast(s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    function automatic int seq_length(input logic [7:0] b);
        if (b < 8'h80) return 1;
        if ((b & 8'hE0) == 8'hC0) return 2;
        if ((b & 8'hF0) == 8'hE0) return 3;
        if ((b & 8'hF8) == 8'hF0) return 4;
        return 0;
    endfunction

    task automatic decode_byte(input logic [7:0] din, input logic fin);
        logic [7:0]  seq[4];
        span_t       run[4];
        int          n, head, len, avail, lim, k;
        bit          cont_ok, ok;
        int unsigned v;
        for (int i = 0; i < 3; i++) seq[i] = open_bytes[i];
        seq[3] = 8'h00;
        n = open_count;
        seq[n] = din;
        n++;
        head = 0;
        k = 0;
        while (head < n) begin
            len = seq_length(seq[head]);
            avail = n - head;
            ok = 1'b0;
            v = 0;
            if (len != 0) begin
                cont_ok = 1'b1;
                lim = (len < avail) ? len : avail;
                for (int i = 1; i < lim; i++) begin
                    if (seq[head + i][7:6] != 2'b10) cont_ok = 1'b0;
                end
                if (cont_ok && avail < len && !fin) break;
                if (cont_ok && avail >= len) begin
                    case (len)
                        1: v = 32'(seq[head]);
                        2: v = 32'(seq[head] & 8'h1F);
                        3: v = 32'(seq[head] & 8'h0F);
                        default: v = 32'(seq[head] & 8'h07);
                    endcase
                    for (int i = 1; i < len; i++) v = (v << 6) | 32'(seq[head + i][5:0]);
                    ok = !((len == 2 && v < 'h80) || (len == 3 && v < 'h800) ||
                           (len == 4 && v < 'h10000) || (v >= 'hD800 && v <= 'hDFFF) ||
                           v > 'h10FFFF);
                end
            end
            run[k].code_point = ok ? v[20:0] : utf8vd_pkg::MARKER_BASE + {13'd0, seq[head]};
            run[k].start_off = text_pos;
            text_pos = text_pos + (ok ? len : 1);
            run[k].end_off = text_pos;
            run[k].well_formed = ok;
            run[k].last_of_run = 1'b0;
            run[k].text_done = 1'b0;
            head += ok ? len : 1;
            k++;
        end
        open_count = n - head;
        for (int i = 0; i < open_count; i++) open_bytes[i] = seq[head + i];
        if (k > 0) begin
            run[k - 1].last_of_run = 1'b1;
            run[k - 1].text_done = fin;
        end
        for (int i = 0; i < k; i++) expected_spans.insert(expected_spans.size(), run[i]);
        if (fin) begin
            open_count = 0;
            text_pos = 32'd0;
        end
    endtask

    task automatic queue_byte(input logic [7:0] b, input logic eot);
        text_byte_t item;
        item.data = b;
        item.eot = eot;
        item.drain_first = hold_next;
        hold_next = 1'b0;
        text_bytes.insert(text_bytes.size(), item);
    endtask

    function automatic logic random_eot();
        return ($urandom_range(0, 24) == 0);
    endfunction

    function automatic logic [7:0] random_cont();
        return {2'b10, 6'($urandom_range(0, 63))};
    endfunction

    function automatic int unsigned random_scalar();
        int unsigned lo, hi, cp;
        case ($urandom_range(1, 4))
            1: begin lo = 'h0; hi = 'h7F; end
            2: begin lo = 'h80; hi = 'h7FF; end
            3: begin lo = 'h800; hi = 'hFFFF; end
            default: begin lo = 'h10000; hi = 'h10FFFF; end
        endcase
        case ($urandom_range(0, 7))
            0: cp = lo;
            1: cp = hi;
            default: cp = $urandom_range(lo, hi);
        endcase
        if (cp >= 'hD800 && cp <= 'hDFFF) cp = $urandom_range(0, 1) ? 'hD7FF : 'hE000;
        return cp;
    endfunction

    task automatic queue_scalar(input int unsigned cp);
        if (cp < 'h80) begin
            queue_byte(cp[7:0], random_eot());
        end else if (cp < 'h800) begin
            queue_byte({3'b110, cp[10:6]}, random_eot());
            queue_byte({2'b10, cp[5:0]}, random_eot());
        end else if (cp < 'h10000) begin
            queue_byte({4'b1110, cp[15:12]}, random_eot());
            queue_byte({2'b10, cp[11:6]}, random_eot());
            queue_byte({2'b10, cp[5:0]}, random_eot());
        end else begin
            queue_byte({5'b11110, cp[20:18]}, random_eot());
            queue_byte({2'b10, cp[17:12]}, random_eot());
            queue_byte({2'b10, cp[11:6]}, random_eot());
            queue_byte({2'b10, cp[5:0]}, random_eot());
        end
    endtask

    task automatic queue_suspect_sequence();
        int         len;
        logic [7:0] lead;
        len = $urandom_range(2, 4);
        case (len)
            2: lead = {3'b110, 5'($urandom_range(0, 3) == 0 ? $urandom_range(0, 1)
                                                            : $urandom_range(0, 31))};
            3: lead = {4'b1110, 4'($urandom_range(0, 2) == 0 ? 0 :
                                  $urandom_range(0, 1) ? 13 : $urandom_range(0, 15))};
            default: lead = {5'b11110, 3'($urandom_range(0, 2) == 0 ? 0 :
                                         $urandom_range(0, 1) ? 4 : $urandom_range(0, 7))};
        endcase
        queue_byte(lead, random_eot());
        for (int i = 1; i < len; i++) queue_byte(random_cont(), random_eot());
    endtask

    task automatic queue_truncated_sequence();
        int len;
        len = $urandom_range(2, 4);
        case (len)
            2: queue_byte({3'b110, 5'($urandom_range(2, 31))}, 1'b0);
            3: queue_byte({4'b1110, 4'($urandom_range(1, 15))}, 1'b0);
            default: queue_byte({5'b11110, 3'($urandom_range(1, 3))}, 1'b0);
        endcase
        for (int i = 0; i < $urandom_range(0, len - 2); i++) begin
            queue_byte({2'b10, 2'($urandom_range(2, 3)), 4'($urandom_range(0, 15))}, 1'b0);
        end
    endtask

    initial begin
        int dice;
        queue_byte(8'h00, 1'b0);
        queue_byte(8'h7F, 1'b0);
        queue_byte(8'hC2, 1'b0);
        queue_byte(8'h80, 1'b0);
        queue_byte(8'hC0, 1'b0);
        queue_byte(8'hAF, 1'b0);
        queue_byte(8'hED, 1'b0);
        queue_byte(8'hA0, 1'b0);
        queue_byte(8'h80, 1'b0);
        queue_byte(8'hEF, 1'b0);
        queue_byte(8'hBF, 1'b0);
        queue_byte(8'hBF, 1'b0);
        queue_byte(8'hF4, 1'b0);
        queue_byte(8'h8F, 1'b0);
        queue_byte(8'hBF, 1'b0);
        queue_byte(8'hBF, 1'b0);
        queue_byte(8'hF4, 1'b0);
        queue_byte(8'h90, 1'b0);
        queue_byte(8'h80, 1'b0);
        queue_byte(8'h80, 1'b0);
        queue_byte(8'h80, 1'b0);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'hE2, 1'b0);
        queue_byte(8'h41, 1'b0);
        queue_byte(8'hF0, 1'b0);
        queue_byte(8'h9F, 1'b0);
        queue_byte(8'h98, 1'b1);

        // The sender waits for the directed results to drain before the random text,
        // and once more halfway through it.
        hold_next = 1'b1;
        while (text_bytes.size() < 27 + RANDOM_BYTES) begin
            if (text_bytes.size() >= 27 + RANDOM_BYTES / 2 &&
                text_bytes.size() < 27 + RANDOM_BYTES / 2 + 4) begin
                hold_next = 1'b1;
            end
            dice = $urandom_range(0, 99);
            if (dice < 55) begin
                queue_scalar(random_scalar());
            end else if (dice < 70) begin
                queue_suspect_sequence();
            end else if (dice < 82) begin
                queue_truncated_sequence();
            end else begin
                queue_byte(8'($urandom_range(0, 255)), random_eot());
            end
        end
        queue_byte(8'($urandom_range(0, 127)), 1'b1);

        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;

        while (text_bytes.size() != 0 || s_tvalid) @(posedge aclk);
        while (expected_spans.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);

        if (error_count == 0 && expected_spans.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

    always @(negedge aclk) begin
        text_byte_t item;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || byte_taken) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                s_tvalid <= 1'b0;
            end else if (text_bytes.size() == 0) begin
                s_tvalid <= 1'b0;
            end else if (text_bytes[0].drain_first && expected_spans.size() != 0) begin
                s_tvalid <= 1'b0;
            end else begin
                item = text_bytes.pop_front();
                s_tdata <= item.data;
                s_tlast <= item.eot;
                s_tvalid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end
        end
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (phase_left == 0) begin
                ready_mode <= ready_mode_t'($urandom_range(0, 3));
                phase_left <= $urandom_range(20, 120);
            end else begin
                phase_left <= phase_left - 1;
            end
            stall_pattern <= {stall_pattern[6:0], stall_pattern[7]};
            case (ready_mode)
                RDY_ALWAYS: m_tready <= 1'b1;
                RDY_RANDOM: m_tready <= ($urandom_range(0, 3) != 0);
                RDY_PATTERN: m_tready <= stall_pattern[0];
                default: m_tready <= ($urandom_range(0, 4) == 0);
            endcase
        end
    end

    always @(posedge aclk) begin
        span_t got, want;
        if (!aresetn) begin
            byte_taken <= 1'b0;
        end else begin
            byte_taken <= s_tvalid && s_tready;
            if (s_tvalid && s_tready) decode_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready) begin
                got.code_point = m_tdata[20:0];
                got.start_off = m_tdata[52:21];
                got.end_off = m_tdata[84:53];
                got.well_formed = m_tuser[0];
                got.last_of_run = m_tuser[1];
                got.text_done = m_tlast;
                if (expected_spans.size() == 0) begin
                    error_count++;
                    if (error_count <= 10) begin
                        $display("Unexpected result transfer: cp=%h start=%0d end=%0d user=%b last=%b",
                                 got.code_point, got.start_off, got.end_off, m_tuser, m_tlast);
                    end
                end else begin
                    want = expected_spans.pop_front();
                    if (got !== want) begin
                        error_count++;
                        if (error_count <= 10) begin
                            $display("Mismatch: expected cp=%h start=%0d end=%0d ok=%b run=%b done=%b",
                                     want.code_point, want.start_off, want.end_off,
                                     want.well_formed, want.last_of_run, want.text_done);
                            $display("          actual   cp=%h start=%0d end=%0d ok=%b run=%b done=%b",
                                     got.code_point, got.start_off, got.end_off,
                                     got.well_formed, got.last_of_run, got.text_done);
                        end
                    end
                end
            end
        end
    end

endmodule

// File: utf8_validating_decoder.f
+incdir+hdl
hdl/utf8vd_pkg.sv
hdl/utf8vd_front.sv
hdl/utf8vd_queue.sv
hdl/utf8vd_back.sv
hdl/utf8_validating_decoder.sv
sim/tb_utf8_validating_decoder.sv
